// File: design/strs_pkg.sv
`timescale 1ns / 1ps

package strs_pkg;

    // Element capacity and derived node-store geometry (leaves at MAX_ELEMENTS + index)
    localparam int MAX_ELEMENTS = 1024;
    localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
    localparam int ADDR_W       = $clog2(NODE_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REGSEL_W = PADDR_W - 2;

    localparam logic [COUNT_W-1:0]  COUNT_RESET       = 11'd1;
    localparam logic [REGSEL_W-1:0] REG_ELEMENT_COUNT = 1'b0;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef logic [ADDR_W-1:0] node_addr_t;
    typedef logic [PTR_W-1:0]  node_ptr_t;
    typedef logic [DATA_W-1:0] word_t;

endpackage

// File: design/strs_node_ram.sv
`timescale 1ns / 1ps

// Node store: one write port, two read ports, registered read data.
module strs_node_ram
(
    input  logic                clk,
    input  logic                wr_en,
    input  strs_pkg::node_addr_t wr_addr,
    input  strs_pkg::word_t     wr_data,
    input  strs_pkg::node_addr_t rd_a_addr,
    output strs_pkg::word_t     rd_a_data,
    input  strs_pkg::node_addr_t rd_b_addr,
    output strs_pkg::word_t     rd_b_data
);

    strs_pkg::word_t mem [strs_pkg::NODE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// File: design/segment_tree_range_sum_unit.sv
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------------
// request   | req_valid/ready    | op, element_index, element_value, range_start, range_end
// response  | rsp_valid/ready    | range_sum, status (one per query, none per load)
// config    | APB psel/penable   | element_count at byte address 0
//
// A load does a leaf read, then a read-add-write of each of the 10
// ancestors, one per cycle on the node store's single write port.
// A valid query walks bottom-up, issuing two node reads per tree level on the
// two read ports (11 levels), then does a final add and returns the result.
// An invalid range skips the walk and answers with status invalid and a zero sum.
// After reset a clearing pass writes zero to all 2048 node entries;
// req_ready stays low until it ends. APB writes are taken at any time.
// A finished result waits in the response register; while it stalls, loads
// flow until the next query finishes, which then blocks further requests.

module segment_tree_range_sum_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                op,
    input  logic [strs_pkg::INDEX_W-1:0]        element_index,
    input  logic signed [strs_pkg::DATA_W-1:0]  element_value,
    input  logic [strs_pkg::INDEX_W-1:0]        range_start,
    input  logic [strs_pkg::INDEX_W-1:0]        range_end,

    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [strs_pkg::DATA_W-1:0]  range_sum,
    output logic                                status,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [strs_pkg::PADDR_W-1:0]        paddr,
    input  logic [strs_pkg::PDATA_W-1:0]        pwdata,
    output logic [strs_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LD_LEAF = 3'd2;
    localparam logic [2:0] ST_LD_UP   = 3'd3;
    localparam logic [2:0] ST_Q_WALK  = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    localparam int PTR_W  = strs_pkg::PTR_W;
    localparam int ADDR_W = strs_pkg::ADDR_W;

    // control state
    logic [2:0]                    state_reg, state_next;
    strs_pkg::node_ptr_t           clr_reg, clr_next;
    logic [strs_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          take_a_reg, take_a_next;
    logic                          take_b_reg, take_b_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    // datapath
    strs_pkg::node_addr_t          node_reg, node_next;
    strs_pkg::node_ptr_t           l_reg, l_next;
    strs_pkg::node_ptr_t           r_reg, r_next;
    strs_pkg::word_t               sum_reg, sum_next;
    logic                          status_reg, status_next;
    strs_pkg::word_t               value_reg, value_next;
    strs_pkg::word_t               delta_reg, delta_next;
    strs_pkg::word_t               rsp_sum_reg, rsp_sum_next;
    logic                          rsp_status_reg, rsp_status_next;

    // node store ports
    logic                          wr_en;
    strs_pkg::node_addr_t          wr_addr;
    strs_pkg::word_t               wr_data;
    strs_pkg::node_addr_t          rd_a_addr;
    strs_pkg::node_addr_t          rd_b_addr;
    strs_pkg::word_t               rd_a_data;
    strs_pkg::word_t               rd_b_data;

    logic                          accept;
    logic                          out_free;
    logic                          query_ok;
    logic                          leaf_ok;
    strs_pkg::node_addr_t          leaf_addr;
    logic                          cfg_write;
    strs_pkg::word_t               add_a;
    strs_pkg::word_t               add_b;

    strs_node_ram u_node_ram
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign range_sum = rsp_sum_reg;
    assign status    = rsp_status_reg;

    // Range is valid when end < min(element_count, capacity) and start <= end.
    assign query_ok = ({1'b0, range_end} < count_reg)
                   && (32'(range_end) < 32'(strs_pkg::MAX_ELEMENTS))
                   && (range_start <= range_end);

    assign leaf_ok   = 32'(element_index) < 32'(strs_pkg::MAX_ELEMENTS);
    assign leaf_addr = ADDR_W'(32'(strs_pkg::MAX_ELEMENTS) + 32'(element_index));

    // APB: zero-wait, single register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[strs_pkg::PADDR_W-1:2] == strs_pkg::REG_ELEMENT_COUNT)
        begin
            prdata = strs_pkg::PDATA_W'(count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_write && (paddr[strs_pkg::PADDR_W-1:2] == strs_pkg::REG_ELEMENT_COUNT))
        begin
            count_next = pwdata[strs_pkg::COUNT_W-1:0];
        end
    end

    assign add_a = take_a_reg ? rd_a_data : '0;
    assign add_b = take_b_reg ? rd_b_data : '0;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        take_a_next     = take_a_reg;
        take_b_next     = take_b_reg;
        node_next       = node_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        sum_next        = sum_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        delta_next      = delta_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_sum_next    = rsp_sum_reg;
        rsp_status_next = rsp_status_reg;

        wr_en     = 1'b0;
        wr_addr   = node_reg;
        wr_data   = '0;
        rd_a_addr = node_reg;
        rd_b_addr = node_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg[ADDR_W-1:0];
                wr_data  = '0;
                clr_next = clr_reg + PTR_W'(1);
                if (clr_reg == PTR_W'(strs_pkg::NODE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == strs_pkg::OP_LOAD)
                    begin
                        // out-of-store index: nothing to write
                        if (leaf_ok)
                        begin
                            rd_a_addr  = leaf_addr;
                            node_next  = leaf_addr;
                            value_next = element_value;
                            state_next = ST_LD_LEAF;
                        end
                    end
                    else if (query_ok)
                    begin
                        l_next      = PTR_W'(32'(strs_pkg::MAX_ELEMENTS) + 32'(range_start));
                        r_next      = PTR_W'(32'(strs_pkg::MAX_ELEMENTS) + 32'(range_end) + 1);
                        sum_next    = '0;
                        take_a_next = 1'b0;
                        take_b_next = 1'b0;
                        state_next  = ST_Q_WALK;
                    end
                    else
                    begin
                        sum_next    = '0;
                        status_next = strs_pkg::STATUS_INVALID;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_LD_LEAF:
            begin
                // old leaf value is on port A; propagate the difference upward
                delta_next = value_reg - rd_a_data;
                wr_en      = 1'b1;
                wr_addr    = node_reg;
                wr_data    = value_reg;
                if (node_reg == ADDR_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_a_addr  = node_reg >> 1;
                    node_next  = node_reg >> 1;
                    state_next = ST_LD_UP;
                end
            end

            ST_LD_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                wr_data = rd_a_data + delta_reg;
                if (node_reg == ADDR_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_a_addr = node_reg >> 1;
                    node_next = node_reg >> 1;
                end
            end

            ST_Q_WALK:
            begin
                // fold in the nodes read last cycle
                sum_next = sum_reg + add_a + add_b;
                if (l_reg < r_reg)
                begin
                    // half-open [l, r): odd l is a right child, odd r closes a left one
                    take_a_next = l_reg[0];
                    take_b_next = r_reg[0];
                    rd_a_addr   = l_reg[ADDR_W-1:0];
                    rd_b_addr   = ADDR_W'(r_reg - PTR_W'(1));
                    l_next      = (l_reg + PTR_W'(l_reg[0])) >> 1;
                    r_next      = r_reg >> 1;
                end
                else
                begin
                    take_a_next = 1'b0;
                    take_b_next = 1'b0;
                    status_next = strs_pkg::STATUS_OK;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_sum_next    = sum_reg;
                    rsp_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= strs_pkg::COUNT_RESET;
            take_a_reg    <= 1'b0;
            take_b_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            take_a_reg    <= take_a_next;
            take_b_reg    <= take_b_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        l_reg          <= l_next;
        r_reg          <= r_next;
        sum_reg        <= sum_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        delta_reg      <= delta_next;
        rsp_sum_reg    <= rsp_sum_next;
        rsp_status_reg <= rsp_status_next;
    end

endmodule

// File: design/strs_port_checker.sv
`timescale 1ns / 1ps

module strs_port_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic signed [strs_pkg::DATA_W-1:0]  range_sum,
    input  logic                                status
);

    // one transaction in flight: an accepted request drops ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous transaction still busy");

    // invalid range always reports zero sum
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == strs_pkg::STATUS_INVALID) |-> (range_sum == '0))
        else $error("invalid status with nonzero sum");

    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !req_ready)
        else $error("request taken before node store cleared");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(range_sum) && $stable(status))
        else $error("response dropped or changed while stalled");

endmodule

bind segment_tree_range_sum_unit strs_port_checker u_strs_port_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

// Range-sum unit bench.
// The bench first loads a strided set of elements across the whole array; the
// rest read as zero until they are loaded. A short directed pass covers the
// extremes, wraparound and invalid ranges, and it writes the element count at
// 0, 1, 2047 and 1025. After that, random phases each set a new count and send
// a mix of loads and queries.
// The scoreboard keeps a flat copy of the element array. A query's expected
// sum is a plain wrapped add over the range, which a correct tree walk must
// match.

module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LOAD_SETTLE  = 20;   // a load runs with no response
    localparam int PHASE_ITEMS  = 24;
    localparam int INIT_LOADS   = 128;
    localparam int INIT_STRIDE  = strs_pkg::MAX_ELEMENTS / INIT_LOADS;

    typedef logic [strs_pkg::INDEX_W-1:0] index_t;
    typedef logic [strs_pkg::COUNT_W-1:0] count_t;

    typedef struct {
        strs_pkg::word_t sum;
        logic            status;
    } query_result_t;

    // Scoreboard: mirrors the element store and the count register, and queues
    // one expected result per accepted query.
    class range_sum_scoreboard;
        strs_pkg::word_t    element_mem [strs_pkg::MAX_ELEMENTS];
        count_t             element_count = strs_pkg::COUNT_RESET;
        query_result_t      expected_q [$];
        int                 errors = 0;

        function new();
            foreach (element_mem[i])
                element_mem[i] = '0;
        endfunction

        // Counts above capacity saturate.
        function int unsigned live_count();
            return (element_count > strs_pkg::MAX_ELEMENTS) ? strs_pkg::MAX_ELEMENTS
                                                            : element_count;
        endfunction

        function void set_count(count_t value);
            element_count = value;
        endfunction

        function void note_request(logic kind, index_t idx, strs_pkg::word_t value,
                                   index_t first, index_t last);
            query_result_t r;
            int unsigned   n;
            if (kind == strs_pkg::OP_LOAD)
            begin
                element_mem[idx] = value;
                return;
            end
            n = live_count();
            r.sum = '0;
            if (n == 0 || last >= n || first > last)
            begin
                r.status = strs_pkg::STATUS_INVALID;
            end
            else
            begin
                for (int i = first; i <= last; i++)
                    r.sum += element_mem[i];
                r.status = strs_pkg::STATUS_OK;
            end
            expected_q.push_back(r);
        endfunction

        function void check_response(strs_pkg::word_t sum, logic st);
            query_result_t r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: response with none expected: sum %h status %b", $time, sum, st);
                return;
            end
            r = expected_q.pop_front();
            if (sum !== r.sum)
            begin
                errors++;
                $display("%0t: range_sum expected %h actual %h", $time, r.sum, sum);
            end
            if (st !== r.status)
            begin
                errors++;
                $display("%0t: status expected %b actual %b", $time, r.status, st);
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                req_valid;
    logic                                req_ready;
    logic                                op;
    index_t                              element_index;
    logic signed [strs_pkg::DATA_W-1:0]  element_value;
    index_t                              range_start;
    index_t                              range_end;
    logic                                rsp_valid;
    logic                                rsp_ready;
    logic signed [strs_pkg::DATA_W-1:0]  range_sum;
    logic                                status;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [strs_pkg::PADDR_W-1:0]        paddr;
    logic [strs_pkg::PDATA_W-1:0]        pwdata;
    logic [strs_pkg::PDATA_W-1:0]        prdata;
    logic                                pready;

    range_sum_scoreboard sb;
    bit                  no_idle = 1'b0;   // both sides run back to back when set
    int unsigned         cycle_count = 0;

    segment_tree_range_sum_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .op            (op),
        .element_index (element_index),
        .element_value (element_value),
        .range_start   (range_start),
        .range_end     (range_end),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .range_sum     (range_sum),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Hard stop, sized from the slowest legal run with a wide margin.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Response monitor: a transaction completes on a rising edge with valid and ready.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(range_sum, status);
    end

    // Response-side backpressure. Each transaction gets a random stall, which may be
    // zero. Ready only drops when a stall is drawn, so it never toggles twice in one
    // step.
    initial
    begin : rsp_stall
        int unsigned gap;
        rsp_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    // Random filler for fields the operation ignores.
    function automatic index_t rand_index();
        return index_t'($urandom);
    endfunction

    // Sends one request transaction. Called at a falling edge; returns at a falling edge.
    task automatic send_item(logic kind, index_t idx, strs_pkg::word_t value,
                             index_t first, index_t last);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op            <= kind;
        element_index <= idx;
        element_value <= value;
        range_start   <= first;
        range_end     <= last;
        req_valid     <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_request(kind, idx, value, first, last);
        @(negedge clk);
    endtask

    // Stop sending and wait until every query has been answered. Then wait out
    // any load that may still be updating the tree.
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (LOAD_SETTLE) @(negedge clk);
    endtask

    // APB write, setup then access phase. Call only while the unit is idle; it is not checked.
    task automatic write_count(count_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {strs_pkg::REG_ELEMENT_COUNT, 2'b00};
        pwdata  <= {{(strs_pkg::PDATA_W-strs_pkg::COUNT_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_count(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly full-range random data, with the sign and wrap extremes now and then.
    function automatic strs_pkg::word_t pick_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic rand_load();
        int unsigned n;
        index_t      idx;
        n = sb.live_count();
        // Mostly inside the live range; the rest may land beyond it and show up later.
        if (n != 0 && $urandom_range(0, 9) < 7)
            idx = index_t'($urandom_range(0, n - 1));
        else
            idx = index_t'($urandom_range(0, strs_pkg::MAX_ELEMENTS - 1));
        send_item(strs_pkg::OP_LOAD, idx, pick_value(), rand_index(), rand_index());
    endtask

    task automatic rand_query();
        int unsigned n;
        int unsigned pick;
        int unsigned span;
        index_t      first;
        index_t      last;
        n    = sb.live_count();
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 15)
        begin
            // Invalid: the end is past the count, or the start is after the end.
            if (n < strs_pkg::MAX_ELEMENTS && pick[0])
            begin
                last  = index_t'($urandom_range(n, strs_pkg::MAX_ELEMENTS - 1));
                first = index_t'($urandom_range(0, last));
            end
            else
            begin
                first = index_t'($urandom_range(1, strs_pkg::MAX_ELEMENTS - 1));
                last  = index_t'($urandom_range(0, first - 1));
            end
        end
        else if (pick < 45)
        begin
            // Short ranges stress the partial-overlap splits near the leaves.
            first = index_t'($urandom_range(0, n - 1));
            span  = $urandom_range(0, 7);
            last  = (first + span > n - 1) ? index_t'(n - 1) : index_t'(first + span);
        end
        else
        begin
            first = index_t'($urandom_range(0, n - 1));
            last  = index_t'($urandom_range(first, n - 1));
        end
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, first, last);
    endtask

    initial
    begin : stimulus
        count_t phase_counts [12];
        sb = new();

        phase_counts = '{11'd3, 11'd1, 11'd1024, 11'd2, 11'd17, 11'd1000,
                         11'd0, 11'd513, 11'd2047, 11'd1023, 11'd1025, 11'd0};
        phase_counts[11] = count_t'($urandom_range(0, 2047));

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        op            = strs_pkg::OP_LOAD;
        element_index = '0;
        element_value = '0;
        range_start   = '0;
        range_end     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full capacity, then a strided set of elements across the array. The
        // ready handshake covers the clearing pass after reset.
        write_count(11'd1024);
        for (int i = 0; i < INIT_LOADS; i++)
            send_item(strs_pkg::OP_LOAD, index_t'(i * INIT_STRIDE), pick_value(),
                      rand_index(), rand_index());

        // Directed: wraparound at both signed extremes, whole and single-leaf
        // ranges, and start-after-end.
        send_item(strs_pkg::OP_LOAD,  10'd0,    32'h7FFF_FFFF, rand_index(), rand_index());
        send_item(strs_pkg::OP_LOAD,  10'd1,    32'h7FFF_FFFF, rand_index(), rand_index());
        send_item(strs_pkg::OP_LOAD,  10'd1022, 32'h8000_0000, rand_index(), rand_index());
        send_item(strs_pkg::OP_LOAD,  10'd1023, 32'h8000_0000, rand_index(), rand_index());
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0,    10'd1);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd1022, 10'd1023);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0,    10'd1023);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0,    10'd0);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd1023, 10'd1023);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd5,    10'd4);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd1023, 10'd0);
        send_item(strs_pkg::OP_LOAD,  10'd1023, 32'hFFFF_FFFF, rand_index(), rand_index());
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd512,  10'd1023);
        send_item(strs_pkg::OP_LOAD,  10'd0,    32'h0000_0000, rand_index(), rand_index());
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0,    10'd2);

        // With a zero count, every query is invalid.
        drain();
        write_count(11'd0);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0, 10'd0);

        // A single element. The load at 700 lies beyond the count and must stay hidden.
        drain();
        write_count(11'd1);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0, 10'd0);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0, 10'd1);
        send_item(strs_pkg::OP_LOAD,  10'd700, 32'h1234_5678, rand_index(), rand_index());

        // A count above capacity saturates; element 700 is now inside the range.
        drain();
        write_count(11'd2047);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd700, 10'd700);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0,   10'd1023);

        drain();
        write_count(11'd1025);
        send_item(strs_pkg::OP_QUERY, rand_index(), $urandom, 10'd0, 10'd1023);

        // Random phases. Each phase writes a new count, which moves the valid range;
        // the tree is kept. Every third phase runs with no idle cycles on either side.
        foreach (phase_counts[ph])
        begin
            drain();
            write_count(phase_counts[ph]);
            no_idle = (ph % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Hold off mid-phase until the response queue runs dry.
                if (k == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(0, 9) < 4)
                    rand_load();
                else
                    rand_query();
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
